FILE: hdl/assert_macros.svh
// assertion macros shared by the box filter rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BF7_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bf7 check failed");

// next-cycle implication, disabled while reset is asserted
`define BF7_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bf7 check failed");

`endif

FILE: hdl/bf7_pkg.sv
// constants, types and register codes of the 7x7 box filter
// no dependencies
package bf7_pkg;

  localparam int WIN            = 7;
  localparam int HALF           = 3;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int CFG_W          = 11;
  localparam int PIX_W          = 8;
  localparam int HSUM_W         = 11;
  localparam int COL_W          = 14;
  localparam int COORD_W        = 10;
  localparam int SLOT_W         = 3;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;
  localparam int QDEPTH         = 4;
  // floor(x / 49) == (x * 21400) >> 20 for every 14-bit x
  localparam int RECIP          = 21400;
  localparam int RECIP_W        = 15;
  localparam int RECIP_SH       = 20;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  // how the back end treats one horizontal sum
  typedef struct packed {
    logic first_row;
    logic early_row;
    logic emit;
    logic last;
  } bf7_kind_t;

  localparam int KIND_W = $bits(bf7_kind_t);

endpackage

FILE: hdl/bf7_stream_if.sv
// valid/ready stream interfaces for pixels in and filtered results out
// depends on bf7_pkg
interface bf7_pix_if;
  import bf7_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface bf7_res_if;
  import bf7_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   mean_value;
  logic [COORD_W-1:0] centre_row;
  logic [COORD_W-1:0] centre_col;
  logic               frame_last;
  modport source (output valid, output mean_value, output centre_row,
                  output centre_col, output frame_last, input ready);
  modport sink   (input valid, input mean_value, input centre_row,
                  input centre_col, input frame_last, output ready);
endinterface

FILE: hdl/bf7_front.sv
// front end: raster counters, horizontal running sum, classification
// depends on bf7_pkg, bf7_stream_if and assert_macros.svh
`include "assert_macros.svh"
module bf7_front #(
  parameter int MAX_WIDTH  = bf7_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bf7_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bf7_pix_if.sink                         pix,
  input  logic [bf7_pkg::CFG_W-1:0]       cfg_width_i,
  input  logic [bf7_pkg::CFG_W-1:0]       cfg_height_i,
  input  logic                            restart_i,
  input  logic                            full_i,
  output logic                            push_o,
  output logic [bf7_pkg::HSUM_W-1:0]      row_sum_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    cc_o,
  output logic [bf7_pkg::SLOT_W-1:0]      slot_o,
  output logic [bf7_pkg::COORD_W-1:0]     crow_o,
  output bf7_pkg::bf7_kind_t              kind_o
);
  import bf7_pkg::*;

  localparam int CCW  = $clog2(MAX_WIDTH);
  localparam int RWW  = $clog2(MAX_HEIGHT);
  localparam int MWW  = $clog2(MAX_WIDTH + 1);
  localparam int MHW  = $clog2(MAX_HEIGHT + 1);
  localparam int EWW  = (MWW > CFG_W) ? MWW : CFG_W;
  localparam int EHW  = (MHW > CFG_W) ? MHW : CFG_W;

  logic [PIX_W-1:0]  win_q [WIN];
  logic [PIX_W-1:0]  win_d [WIN];
  logic [HSUM_W-1:0] row_sum_q, row_sum_d;
  logic [CCW-1:0]    col_q;
  logic [RWW-1:0]    row_q;
  logic [SLOT_W-1:0] slot_q;
  logic [EWW-1:0]    w_ext, w_eff;
  logic [EHW-1:0]    h_ext, h_eff;
  logic              acc, col0, col_last, row_last;
  logic [HSUM_W-1:0] base, oldest;

  // clamp frame size to the supported range
  always_comb begin
    w_ext = EWW'(cfg_width_i);
    h_ext = EHW'(cfg_height_i);
    if (w_ext < EWW'(WIN)) w_eff = EWW'(WIN);
    else if (w_ext > EWW'(MAX_WIDTH)) w_eff = EWW'(MAX_WIDTH);
    else w_eff = w_ext;
    if (h_ext < EHW'(WIN)) h_eff = EHW'(WIN);
    else if (h_ext > EHW'(MAX_HEIGHT)) h_eff = EHW'(MAX_HEIGHT);
    else h_eff = h_ext;
  end

  assign pix.ready = !full_i;
  assign acc       = pix.valid && !full_i;
  assign col0      = (col_q == '0);
  assign col_last  = (EWW'(col_q) == w_eff - EWW'(1));
  assign row_last  = (EHW'(row_q) == h_eff - EHW'(1));

  // horizontal running sum, cleared at each row start
  always_comb begin
    base      = col0 ? '0 : row_sum_q;
    oldest    = col0 ? '0 : HSUM_W'(win_q[WIN-1]);
    row_sum_d = base + HSUM_W'(pix.pixel) - oldest;
    win_d[0]  = pix.pixel;
    for (int i = 1; i < WIN; i++) begin
      win_d[i] = col0 ? '0 : win_q[i-1];
    end
  end

  // hand a sum to the back end once seven pixels of the row are in
  assign push_o           = acc && (col_q >= CCW'(WIN - 1));
  assign row_sum_o        = row_sum_d;
  assign cc_o             = col_q - CCW'(HALF);
  assign slot_o           = slot_q;
  assign crow_o           = COORD_W'(row_q - RWW'(HALF));
  assign kind_o.first_row = (row_q == '0);
  assign kind_o.early_row = (row_q < RWW'(WIN));
  assign kind_o.emit      = (row_q >= RWW'(WIN - 1));
  assign kind_o.last      = row_last && col_last;

  // raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      slot_q    <= '0;
      row_sum_q <= '0;
    end else if (restart_i) begin
      col_q     <= '0;
      row_q     <= '0;
      slot_q    <= '0;
      row_sum_q <= '0;
    end else if (acc) begin
      row_sum_q <= row_sum_d;
      if (col_last) begin
        col_q <= '0;
        if (row_last) begin
          row_q  <= '0;
          slot_q <= '0;
        end else begin
          row_q  <= row_q + RWW'(1);
          slot_q <= (slot_q == SLOT_W'(WIN - 1)) ? '0 : slot_q + SLOT_W'(1);
        end
      end else begin
        col_q <= col_q + CCW'(1);
      end
    end
  end

  // pixel window shift line
  always_ff @(posedge clk_i) begin
    if (acc) begin
      for (int i = 0; i < WIN; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  `BF7_ASSERT_IMP(a_push_interior, clk_i, rst_ni, push_o, col_q >= CCW'(WIN - 1))
  `BF7_ASSERT_IMP(a_slot_range, clk_i, rst_ni, 1'b1, slot_q < SLOT_W'(WIN))

endmodule

FILE: hdl/bf7_queue.sv
// short fifo between front and back ends
// depends on bf7_pkg and assert_macros.svh
`include "assert_macros.svh"
module bf7_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = bf7_pkg::QDEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o
);
  import bf7_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PW'(1);
      if (pop_i)  rd_q <= rd_q + PW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  `BF7_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i, !full_o)
  `BF7_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o)

endmodule

FILE: hdl/bf7_back.sv
// back end: line buffer, column sums, divide by 49, output register
// depends on bf7_pkg, bf7_stream_if and assert_macros.svh
`include "assert_macros.svh"
module bf7_back #(
  parameter int MAX_WIDTH = bf7_pkg::DEF_MAX_WIDTH,
  parameter int DW        = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  logic [DW-1:0] qdata_i,
  output logic          pop_o,
  bf7_res_if.source     res
);
  import bf7_pkg::*;

  localparam int CCW = $clog2(MAX_WIDTH);

  logic [COL_W-1:0]  colmem [MAX_WIDTH];
  logic [HSUM_W-1:0] hmem   [WIN][MAX_WIDTH];

  logic [HSUM_W-1:0]  q_rsum;
  logic [CCW-1:0]     q_cc;
  logic [SLOT_W-1:0]  q_slot;
  logic [COORD_W-1:0] q_crow;
  bf7_kind_t          q_kind;

  logic               s1_v_q, s2_v_q, out_v_q;
  logic [HSUM_W-1:0]  s1_rsum_q;
  logic [CCW-1:0]     s1_cc_q, s2_cc_q;
  logic [SLOT_W-1:0]  s1_slot_q;
  logic [COORD_W-1:0] s1_crow_q, s2_crow_q;
  bf7_kind_t          s1_kind_q, s2_kind_q;
  logic [COL_W-1:0]   col_rd_q, byp_col_q, s2_col_q;
  logic [HSUM_W-1:0]  h_rd_q;
  logic               byp_q;
  logic [COL_W-1:0]   col_src, s1_col;
  logic               out_free, s2_free, s1_fire, s1_adv;
  logic [COL_W+RECIP_W-1:0] prod;

  logic [PIX_W-1:0]   mean_q;
  logic [COORD_W-1:0] orow_q, ocol_q;
  logic               olast_q;

  assign {q_rsum, q_cc, q_slot, q_crow, q_kind} = qdata_i;

  // stage flow control
  assign out_free = !out_v_q || res.ready;
  assign s2_free  = !s2_v_q || out_free;
  assign s1_fire  = s1_v_q && s2_free;
  assign s1_adv   = !s1_v_q || s2_free;
  assign pop_o    = s1_adv && !empty_i;

  // vertical running sum, with forwarding of a same-column write
  always_comb begin
    col_src = byp_q ? byp_col_q : col_rd_q;
    if (s1_kind_q.first_row)      s1_col = COL_W'(s1_rsum_q);
    else if (s1_kind_q.early_row) s1_col = col_src + COL_W'(s1_rsum_q);
    else s1_col = col_src - COL_W'(h_rd_q) + COL_W'(s1_rsum_q);
  end

  assign prod = COL_W'(s2_col_q) * RECIP_W'(RECIP);

  // valid bits of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_adv)   s1_v_q  <= !empty_i;
      if (s2_free)  s2_v_q  <= s1_v_q;
      if (out_free) out_v_q <= s2_v_q && s2_kind_q.emit;
    end
  end

  // memory reads on pop, writes when stage one moves on
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      col_rd_q  <= colmem[q_cc];
      h_rd_q    <= hmem[q_slot][q_cc];
      byp_q     <= s1_fire && (s1_cc_q == q_cc);
      byp_col_q <= s1_col;
      s1_rsum_q <= q_rsum;
      s1_cc_q   <= q_cc;
      s1_slot_q <= q_slot;
      s1_crow_q <= q_crow;
      s1_kind_q <= q_kind;
    end
    if (s1_fire) begin
      colmem[s1_cc_q]          <= s1_col;
      hmem[s1_slot_q][s1_cc_q] <= s1_rsum_q;
    end
  end

  // stage two and output payload
  always_ff @(posedge clk_i) begin
    if (s2_free) begin
      s2_col_q  <= s1_col;
      s2_cc_q   <= s1_cc_q;
      s2_crow_q <= s1_crow_q;
      s2_kind_q <= s1_kind_q;
    end
    if (out_free) begin
      mean_q  <= prod[RECIP_SH +: PIX_W];
      orow_q  <= s2_crow_q;
      ocol_q  <= COORD_W'(s2_cc_q);
      olast_q <= s2_kind_q.last;
    end
  end

  assign res.valid      = out_v_q;
  assign res.mean_value = mean_q;
  assign res.centre_row = orow_q;
  assign res.centre_col = ocol_q;
  assign res.frame_last = olast_q;

  `BF7_ASSERT_NXT(a_s1_moves, clk_i, rst_ni, s1_fire, s2_v_q)
  `BF7_ASSERT_IMP(a_pop_space, clk_i, rst_ni, pop_o, !s1_v_q || s2_free)

endmodule

FILE: hdl/box_filter_7x7_stream_unit.sv
// A pixel passes the queue, line buffer read stage, column sum stage and divider.
// Throughput: one pixel per cycle, set by one line buffer access per pixel,
// unless a full queue or a low res_out.ready stalls the flow. Reset clears
// counters, valid bits and the size registers (640 x 480); the line buffer
// and column sums need no clearing, row 0 overwrites them.
// depends on bf7_pkg, bf7_stream_if, bf7_front, bf7_queue and bf7_back
module box_filter_7x7_stream_unit #(
  parameter int MAX_WIDTH  = bf7_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bf7_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bf7_pkg::ADDR_W-1:0]  paddr,
  input  logic [bf7_pkg::DATA_W-1:0]  pwdata,
  output logic [bf7_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  bf7_pix_if.sink                     pix_in,
  bf7_res_if.source                   res_out
);
  import bf7_pkg::*;

  localparam int CCW = $clog2(MAX_WIDTH);
  localparam int DW  = HSUM_W + CCW + SLOT_W + COORD_W + KIND_W;

  logic [CFG_W-1:0]   width_q, height_q;
  logic               wr_en;
  reg_idx_e           reg_idx;

  logic               push, full, pop, empty;
  logic [HSUM_W-1:0]  f_rsum;
  logic [CCW-1:0]     f_cc;
  logic [SLOT_W-1:0]  f_slot;
  logic [COORD_W-1:0] f_crow;
  bf7_kind_t          f_kind;
  logic [DW-1:0]      qin, qout;

  // register port
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = DATA_W'(width_q);
      REG_HEIGHT: prdata = DATA_W'(height_q);
      default:    prdata = '0;
    endcase
  end

  bf7_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix          (pix_in),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .restart_i    (wr_en),
    .full_i       (full),
    .push_o       (push),
    .row_sum_o    (f_rsum),
    .cc_o         (f_cc),
    .slot_o       (f_slot),
    .crow_o       (f_crow),
    .kind_o       (f_kind)
  );

  assign qin = {f_rsum, f_cc, f_slot, f_crow, f_kind};

  bf7_queue #(.DW(DW), .DEPTH(QDEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (qin),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (qout),
    .empty_o (empty)
  );

  bf7_back #(.MAX_WIDTH(MAX_WIDTH), .DW(DW)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .qdata_i (qout),
    .pop_o   (pop),
    .res     (res_out)
  );

endmodule
